/* hw/rtl/nearest_palette_color_mapper_macros.svh */
// Assertion macros used by the checker file of the palette mapper.
`ifndef NEAREST_PALETTE_COLOR_MAPPER_MACROS_SVH
`define NEAREST_PALETTE_COLOR_MAPPER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NPCM_ASSERT_IMPLY(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("npcm check failed");

// Next-cycle implication, disabled while reset is asserted.
`define NPCM_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("npcm check failed");

`endif

/* hw/rtl/npcm_pkg.sv */
// Types, constants and helper functions of the nearest palette color mapper.
`timescale 1ns / 1ps
package npcm_pkg;

  localparam int CH_W    = 8;
  localparam int SCH_W   = 10;
  localparam int GAIN_W  = 10;
  localparam int COUNT_W = 5;
  localparam int IDX_W   = 4;
  localparam int COLOR_W = 24;
  localparam int DIST_W  = 22;

  localparam logic [CH_W-1:0] REDUCE_MASK = 8'he0;
  localparam logic [CH_W-1:0] CH_MAX      = 8'hff;
  localparam logic [4:0]      DITHER_BIAS = 5'd8;
  localparam int              DITHER_STEP = 255;

  // Indexed [col_phase][row_phase].
  localparam logic [3:0] DITHER_MAP [4][4] = '{
    '{4'd12, 4'd5,  4'd6,  4'd13},
    '{4'd4,  4'd0,  4'd1,  4'd7 },
    '{4'd11, 4'd3,  4'd2,  4'd8 },
    '{4'd15, 4'd10, 4'd9,  4'd14}
  };

  localparam logic MODE_PIXEL     = 1'b0;
  localparam logic MODE_WRITE     = 1'b1;
  localparam logic DIST_SQUARED   = 1'b0;
  localparam logic DIST_MANHATTAN = 1'b1;

  typedef enum logic [2:0] {
    REG_DISTANCE_MODE = 3'd0,
    REG_DITHER_ENABLE = 3'd1,
    REG_REDUCE_ENABLE = 3'd2,
    REG_GAIN_RED      = 3'd3,
    REG_GAIN_GREEN    = 3'd4,
    REG_GAIN_BLUE     = 3'd5,
    REG_PALETTE_COUNT = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic              dither_enable;
    logic              reduce_enable;
    logic [GAIN_W-1:0] gain_red;
    logic [GAIN_W-1:0] gain_green;
    logic [GAIN_W-1:0] gain_blue;
  } pix_cfg_t;

  typedef struct packed {
    logic               distance_mode;
    logic [COUNT_W-1:0] palette_count;
  } search_cfg_t;

  // One word travelling down the cell chain: a pixel or a palette write.
  typedef struct packed {
    logic               valid;
    logic               wr;
    logic [IDX_W-1:0]   widx;
    logic [COLOR_W-1:0] wcolor;
    logic [SCH_W-1:0]   ch_red;
    logic [SCH_W-1:0]   ch_green;
    logic [SCH_W-1:0]   ch_blue;
    logic               found;
    logic [DIST_W-1:0]  best_dist;
    logic [COLOR_W-1:0] best_color;
  } tok_t;

  // max(0, (256*c + 255*(m-8)) >> 8), clamped to 255.
  function automatic logic [CH_W-1:0] dither_channel(logic [CH_W-1:0] c, logic [3:0] m);
    logic signed [5:0]  moff;
    logic signed [17:0] v;
    logic [CH_W-1:0]    res;
    moff = $signed({2'b00, m}) - $signed({1'b0, DITHER_BIAS});
    v    = $signed({2'b00, c, 8'h00}) + (moff * $signed(18'(DITHER_STEP)));
    if (v[17]) begin
      res = '0;
    end else if (v[16]) begin
      res = CH_MAX;
    end else begin
      res = v[15:8];
    end
    return res;
  endfunction

endpackage

/* hw/rtl/npcm_front.sv */
// Front stages: ordered dither and bit reduction, then per-channel gain.
`timescale 1ns / 1ps
module npcm_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            advance,
  input  logic                            take,
  input  npcm_pkg::pix_cfg_t              cfg,
  input  logic                            in_mode,
  input  logic [7:0]                      in_pix_red,
  input  logic [7:0]                      in_pix_green,
  input  logic [7:0]                      in_pix_blue,
  input  logic [1:0]                      in_col_phase,
  input  logic [1:0]                      in_row_phase,
  input  logic [3:0]                      in_entry_index,
  input  logic [23:0]                     in_entry_color,
  output npcm_pkg::tok_t                  tok_o
);
  import npcm_pkg::*;

  logic               a_valid_r;
  logic               a_wr_r;
  logic [IDX_W-1:0]   a_widx_r;
  logic [COLOR_W-1:0] a_wcolor_r;
  logic [CH_W-1:0]    a_red_r, a_green_r, a_blue_r;
  logic [CH_W-1:0]    a_red_nxt, a_green_nxt, a_blue_nxt;
  logic [3:0]         dmap;
  logic [17:0]        prod_red, prod_green, prod_blue;
  tok_t               tok_r, tok_nxt;

  // Optional dither, then optional reduction.
  always_comb begin
    dmap        = DITHER_MAP[in_col_phase][in_row_phase];
    a_red_nxt   = in_pix_red;
    a_green_nxt = in_pix_green;
    a_blue_nxt  = in_pix_blue;
    if (cfg.dither_enable) begin
      a_red_nxt   = dither_channel(in_pix_red, dmap);
      a_green_nxt = dither_channel(in_pix_green, dmap);
      a_blue_nxt  = dither_channel(in_pix_blue, dmap);
    end
    if (cfg.reduce_enable) begin
      a_red_nxt   = a_red_nxt & REDUCE_MASK;
      a_green_nxt = a_green_nxt & REDUCE_MASK;
      a_blue_nxt  = a_blue_nxt & REDUCE_MASK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (advance) begin
      a_valid_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_wr_r     <= (in_mode == MODE_WRITE);
      a_widx_r   <= in_entry_index;
      a_wcolor_r <= in_entry_color;
      a_red_r    <= a_red_nxt;
      a_green_r  <= a_green_nxt;
      a_blue_r   <= a_blue_nxt;
    end
  end

  // Gain: (c * gain) >> 8, fits in ten bits.
  always_comb begin
    prod_red   = {10'b0, a_red_r}   * {8'b0, cfg.gain_red};
    prod_green = {10'b0, a_green_r} * {8'b0, cfg.gain_green};
    prod_blue  = {10'b0, a_blue_r}  * {8'b0, cfg.gain_blue};
    tok_nxt            = '0;
    tok_nxt.valid      = a_valid_r;
    tok_nxt.wr         = a_wr_r;
    tok_nxt.widx       = a_widx_r;
    tok_nxt.wcolor     = a_wcolor_r;
    tok_nxt.ch_red     = prod_red[17:8];
    tok_nxt.ch_green   = prod_green[17:8];
    tok_nxt.ch_blue    = prod_blue[17:8];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else if (advance) begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

/* hw/rtl/npcm_cell.sv */
// One palette cell: holds an entry, scores the passing pixel, keeps the best.
`timescale 1ns / 1ps
module npcm_cell #(
  parameter int CELL_INDEX = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  advance,
  input  npcm_pkg::search_cfg_t cfg,
  input  npcm_pkg::tok_t        tok_i,
  output npcm_pkg::tok_t        tok_o
);
  import npcm_pkg::*;

  logic [COLOR_W-1:0] entry_r;
  tok_t               tok_r, tok_nxt;
  logic [SCH_W-1:0]   p_red, p_green, p_blue;
  logic [SCH_W-1:0]   d_red, d_green, d_blue;
  logic [19:0]        sq_red, sq_green, sq_blue;
  logic [DIST_W-1:0]  score;
  logic               active;
  logic               better;
  logic               write_hit;

  function automatic logic [SCH_W-1:0] abs_diff(logic [SCH_W-1:0] a, logic [SCH_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  always_comb begin
    p_red    = {2'b00, entry_r[23:16]};
    p_green  = {2'b00, entry_r[15:8]};
    p_blue   = {2'b00, entry_r[7:0]};
    d_red    = abs_diff(p_red, tok_i.ch_red);
    d_green  = abs_diff(p_green, tok_i.ch_green);
    d_blue   = abs_diff(p_blue, tok_i.ch_blue);
    sq_red   = 20'(d_red) * 20'(d_red);
    sq_green = 20'(d_green) * 20'(d_green);
    sq_blue  = 20'(d_blue) * 20'(d_blue);
    if (cfg.distance_mode == DIST_MANHATTAN) begin
      score = DIST_W'(d_red) + DIST_W'(d_green) + DIST_W'(d_blue);
    end else begin
      score = DIST_W'(sq_red) + DIST_W'(sq_green) + DIST_W'(sq_blue);
    end
    active    = {27'b0, cfg.palette_count} > 32'(CELL_INDEX);
    better    = !tok_i.found || (score < tok_i.best_dist);
    write_hit = advance && tok_i.valid && tok_i.wr &&
                ({28'b0, tok_i.widx} == 32'(CELL_INDEX));
    tok_nxt = tok_i;
    if (tok_i.valid && !tok_i.wr && active && better) begin
      tok_nxt.found      = 1'b1;
      tok_nxt.best_dist  = score;
      tok_nxt.best_color = entry_r;
    end
  end

  always_ff @(posedge clk) begin
    if (write_hit) begin
      entry_r <= tok_i.wcolor;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else if (advance) begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

/* hw/rtl/nearest_palette_color_mapper.sv */
// Top level of the nearest palette color mapper: config registers, cell chain, output.
//
// Usage:
//   Input words on in_* carry either a pixel (in_mode 0: RGB plus column and
//   row phase) or a palette write (in_mode 1: entry index and 0xRRGGBB color).
//   A word is taken at a rising edge with in_valid high and in_stall low.
//   Each pixel gives one out_red/out_green/out_blue word, the color of the
//   closest palette entry (lowest index on a tie); a palette write gives none.
//   A pixel passes the dither stage, the gain stage, one cell per entry and
//   the output register.
//   Throughput: one word per cycle unless the chain stalls; each word moves one
//   cell per unstalled cycle, so palette writes and pixels stay in order along the chain.
//   Stall: when out_valid is high and out_stall is high the whole chain holds
//   and in_stall rises in the same cycle.
//   Reset (rst_n low, synchronous): registers return to their defaults, the
//   chain and the output empty; palette entries keep their contents and are
//   undefined until written.
//   Configuration: APB-style port, register i at byte address 4*i; write only
//   while no pixel is in flight.
`timescale 1ns / 1ps
module nearest_palette_color_mapper #(
  parameter int PALETTE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [7:0]  in_pix_red,
  input  logic [7:0]  in_pix_green,
  input  logic [7:0]  in_pix_blue,
  input  logic [1:0]  in_col_phase,
  input  logic [1:0]  in_row_phase,
  input  logic [3:0]  in_entry_index,
  input  logic [23:0] in_entry_color,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import npcm_pkg::*;

  // Configuration registers.
  logic               distance_mode_r;
  logic               dither_enable_r;
  logic               reduce_enable_r;
  logic [GAIN_W-1:0]  gain_red_r;
  logic [GAIN_W-1:0]  gain_green_r;
  logic [GAIN_W-1:0]  gain_blue_r;
  logic [COUNT_W-1:0] palette_count_r;

  logic               cfg_write;
  reg_idx_t           cfg_idx;
  pix_cfg_t           pix_cfg;
  search_cfg_t        search_cfg;

  // Chain and output.
  logic               advance;
  logic               take;
  tok_t               chain [PALETTE_DEPTH+1];
  logic               out_valid_r, out_valid_nxt;
  logic [COLOR_W-1:0] out_color_r;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_idx   = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      distance_mode_r <= 1'b0;
      dither_enable_r <= 1'b0;
      reduce_enable_r <= 1'b0;
      gain_red_r      <= 10'd256;
      gain_green_r    <= 10'd256;
      gain_blue_r     <= 10'd256;
      palette_count_r <= 5'd1;
    end else if (cfg_write) begin
      unique case (cfg_idx)
        REG_DISTANCE_MODE: distance_mode_r <= pwdata[0];
        REG_DITHER_ENABLE: dither_enable_r <= pwdata[0];
        REG_REDUCE_ENABLE: reduce_enable_r <= pwdata[0];
        REG_GAIN_RED:      gain_red_r      <= pwdata[GAIN_W-1:0];
        REG_GAIN_GREEN:    gain_green_r    <= pwdata[GAIN_W-1:0];
        REG_GAIN_BLUE:     gain_blue_r     <= pwdata[GAIN_W-1:0];
        REG_PALETTE_COUNT: palette_count_r <= pwdata[COUNT_W-1:0];
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  // Read back; the unused register index 7 (byte address 28) returns zero.
  always_comb begin
    unique case (cfg_idx)
      REG_DISTANCE_MODE: prdata = {31'b0, distance_mode_r};
      REG_DITHER_ENABLE: prdata = {31'b0, dither_enable_r};
      REG_REDUCE_ENABLE: prdata = {31'b0, reduce_enable_r};
      REG_GAIN_RED:      prdata = {22'b0, gain_red_r};
      REG_GAIN_GREEN:    prdata = {22'b0, gain_green_r};
      REG_GAIN_BLUE:     prdata = {22'b0, gain_blue_r};
      REG_PALETTE_COUNT: prdata = {27'b0, palette_count_r};
      default:           prdata = '0;
    endcase
  end

  assign pix_cfg.dither_enable    = dither_enable_r;
  assign pix_cfg.reduce_enable    = reduce_enable_r;
  assign pix_cfg.gain_red         = gain_red_r;
  assign pix_cfg.gain_green       = gain_green_r;
  assign pix_cfg.gain_blue        = gain_blue_r;
  assign search_cfg.distance_mode = distance_mode_r;
  assign search_cfg.palette_count = palette_count_r;

  // Advance everything unless a finished word is held at the output.
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = !advance;
  assign take     = in_valid && advance;

  npcm_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .advance        (advance),
    .take           (take),
    .cfg            (pix_cfg),
    .in_mode        (in_mode),
    .in_pix_red     (in_pix_red),
    .in_pix_green   (in_pix_green),
    .in_pix_blue    (in_pix_blue),
    .in_col_phase   (in_col_phase),
    .in_row_phase   (in_row_phase),
    .in_entry_index (in_entry_index),
    .in_entry_color (in_entry_color),
    .tok_o          (chain[0])
  );

  // One cell per palette entry; a write lands in its cell as it passes, so
  // earlier pixels (already further down) never see it and later ones do.
  for (genvar j = 0; j < PALETTE_DEPTH; j++) begin : g_cell
    npcm_cell #(
      .CELL_INDEX (j)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .advance (advance),
      .cfg     (search_cfg),
      .tok_i   (chain[j]),
      .tok_o   (chain[j+1])
    );
  end

  // Palette writes retire silently at the end of the chain.
  assign out_valid_nxt = chain[PALETTE_DEPTH].valid && !chain[PALETTE_DEPTH].wr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // A search over zero entries leaves best_color at zero: black.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_color_r <= chain[PALETTE_DEPTH].best_color;
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_color_r[23:16];
  assign out_green = out_color_r[15:8];
  assign out_blue  = out_color_r[7:0];

endmodule

/* hw/rtl/npcm_checker.sv */
// Port-level checks of the palette mapper and their bind to the top level.
`timescale 1ns / 1ps
`include "nearest_palette_color_mapper_macros.svh"
module npcm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_red,
  input logic [7:0]  out_green,
  input logic [7:0]  out_blue,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [4:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);
  import npcm_pkg::*;

  // Hold a stalled result word.
  `NPCM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_red) && $stable(out_green) && $stable(out_blue))

  // Input backpressure only comes from a held output word.
  `NPCM_ASSERT_IMPLY(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)

  // Reset empties the output.
  `NPCM_ASSERT_IMPLY(a_reset_empty, clk, rst_n, !$past(rst_n), !out_valid)

  // Red gain readback follows a completed write to it.
  `NPCM_ASSERT_IMPLY(a_gain_readback, clk, rst_n, $past(psel && penable && pwrite && pready && paddr == {REG_GAIN_RED, 2'b00}) && paddr == {REG_GAIN_RED, 2'b00}, prdata[9:0] == $past(pwdata[9:0]))

endmodule

bind nearest_palette_color_mapper npcm_checker u_npcm_checker (.*);

/* test/nearest_palette_color_mapper_tb.sv */
// Self-checking testbench of the nearest palette color mapper: driver, monitor and predictor.
`timescale 1ns / 1ps
module nearest_palette_color_mapper_tb;
  import npcm_pkg::*;

  // Pipeline depth is PALETTE_DEPTH + 3; DRAIN_CYCLES leaves margin beyond it so a
  // palette write that gives no result has surely left the chain.
  localparam int DEPTH        = 16;
  localparam int DRAIN_CYCLES = DEPTH + 10;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_PRINTS   = 40;

  // Ordered dither thresholds, indexed [column phase][row phase].
  localparam logic [3:0] THRESHOLD_MAP [4][4] = '{
    '{4'd12, 4'd5,  4'd6,  4'd13},
    '{4'd4,  4'd0,  4'd1,  4'd7 },
    '{4'd11, 4'd3,  4'd2,  4'd8 },
    '{4'd15, 4'd10, 4'd9,  4'd14}
  };

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // One input word: a pixel or a palette write.
  typedef struct packed {
    logic        mode;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [1:0]  col;
    logic [1:0]  row;
    logic [3:0]  idx;
    logic [23:0] color;
  } word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_mode = MODE_PIXEL;
  logic [7:0]  in_pix_red = '0;
  logic [7:0]  in_pix_green = '0;
  logic [7:0]  in_pix_blue = '0;
  logic [1:0]  in_col_phase = '0;
  logic [1:0]  in_row_phase = '0;
  logic [3:0]  in_entry_index = '0;
  logic [23:0] in_entry_color = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  nearest_palette_color_mapper #(.PALETTE_DEPTH(DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_mode(in_mode),
    .in_pix_red(in_pix_red), .in_pix_green(in_pix_green), .in_pix_blue(in_pix_blue),
    .in_col_phase(in_col_phase), .in_row_phase(in_row_phase),
    .in_entry_index(in_entry_index), .in_entry_color(in_entry_color),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Predictor state: a shadow of the palette and of every register.
  logic [23:0] palette_shadow [DEPTH];
  logic        dist_mode = DIST_SQUARED;
  logic        dither_on = 1'b0;
  logic        reduce_on = 1'b0;
  int          gain_r = 256;
  int          gain_g = 256;
  int          gain_b = 256;
  int          search_count = 1;

  word_t word_queue [$];      // words waiting for the driver
  rgb_t  pending_colors [$];  // predicted colors not yet seen on the output

  logic in_fired = 1'b0;
  logic drain_hold = 1'b0;
  bit   calm = 1'b0;
  int   gap_left = 0;
  int   stall_left = 0;
  int   cycle_count = 0;
  int   mismatches = 0;
  int   pixels_mapped = 0;
  int   entries_written = 0;
  int   settings_used = 0;
  int   drain_pauses = 0;
  int   stalled_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Most gaps are zero or short, a few are long; calm phases run flat out.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Bias channel values toward the ends of the range.
  function automatic logic [7:0] rand_channel();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 8'h00;
    if (r < 20) return 8'hff;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic word_t pixel_word(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                       logic [1:0] col, logic [1:0] row);
    word_t w;
    w.mode = MODE_PIXEL;
    w.red = r;
    w.green = g;
    w.blue = b;
    w.col = col;
    w.row = row;
    w.idx = 4'($urandom_range(0, 15));
    w.color = 24'($urandom_range(0, 24'hffffff));
    return w;
  endfunction

  function automatic word_t entry_word(logic [3:0] idx, logic [23:0] color);
    word_t w;
    w = pixel_word(rand_channel(), rand_channel(), rand_channel(),
                   2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
    w.mode = MODE_WRITE;
    w.idx = idx;
    w.color = color;
    return w;
  endfunction

  // Mostly pixels; some land exactly on a palette color, and some palette
  // writes copy an existing entry so that distance ties occur.
  function automatic word_t random_word();
    word_t w;
    logic [23:0] c;
    w = pixel_word(rand_channel(), rand_channel(), rand_channel(),
                   2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
    if ($urandom_range(0, 99) < 15) begin
      if ($urandom_range(0, 4) == 0) begin
        c = palette_shadow[$urandom_range(0, DEPTH - 1)];
      end else begin
        c = {rand_channel(), rand_channel(), rand_channel()};
      end
      w = entry_word(4'($urandom_range(0, 15)), c);
    end else if ($urandom_range(0, 7) == 0) begin
      {w.red, w.green, w.blue} = palette_shadow[$urandom_range(0, DEPTH - 1)];
    end
    return w;
  endfunction

  function automatic int rand_gain();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 0;
    if (r == 1) return 1023;
    if (r == 2) return 256;
    return $urandom_range(0, 1023);
  endfunction

  // Predict the palette color that a pixel maps to under the current settings.
  function automatic rgb_t nearest_color(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                         logic [1:0] col, logic [1:0] row);
    int ch [3];
    int gains [3];
    int p [3];
    int m, v, cnt, score, best_dist, d;
    bit found;
    rgb_t best;
    ch[0] = r;
    ch[1] = g;
    ch[2] = b;
    gains[0] = gain_r;
    gains[1] = gain_g;
    gains[2] = gain_b;
    best = '0;
    found = 0;
    best_dist = 0;
    if (dither_on) begin
      m = THRESHOLD_MAP[col][row];
      for (int k = 0; k < 3; k++) begin
        v = 256 * ch[k] + 255 * (m - 8);
        if (v < 0) ch[k] = 0;
        else ch[k] = ((v >> 8) > 255) ? 255 : (v >> 8);
      end
    end
    for (int k = 0; k < 3; k++) begin
      if (reduce_on) ch[k] = ch[k] & 'he0;
      ch[k] = (ch[k] * gains[k]) >> 8;
    end
    // Count zero searches nothing; anything past the depth searches all.
    cnt = (search_count > DEPTH) ? DEPTH : search_count;
    for (int j = 0; j < cnt; j++) begin
      p[0] = palette_shadow[j][23:16];
      p[1] = palette_shadow[j][15:8];
      p[2] = palette_shadow[j][7:0];
      score = 0;
      for (int k = 0; k < 3; k++) begin
        d = (p[k] > ch[k]) ? p[k] - ch[k] : ch[k] - p[k];
        score += (dist_mode == DIST_MANHATTAN) ? d : d * d;
      end
      // Strictly less: a tie keeps the lower index.
      if (!found || score < best_dist) begin
        found = 1;
        best_dist = score;
        best = palette_shadow[j];
      end
    end
    return best;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < MAX_PRINTS) $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  // Input driver: change payload only at the falling edge, and only once the
  // current word was taken at the last rising edge (or none is held).
  always @(negedge clk) begin
    word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fired) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (word_queue.size() == 0 || (drain_hold && pending_colors.size() != 0)) begin
        // Nothing to send, or hold off until the output side has drained.
        in_valid <= 1'b0;
      end else begin
        if (drain_hold) drain_pauses++;
        w = word_queue.pop_front();
        in_mode <= w.mode;
        in_pix_red <= w.red;
        in_pix_green <= w.green;
        in_pix_blue <= w.blue;
        in_col_phase <= w.col;
        in_row_phase <= w.row;
        in_entry_index <= w.idx;
        in_entry_color <= w.color;
        in_valid <= 1'b1;
        gap_left <= pick_gap();
        drain_hold <= ($urandom_range(0, 39) == 0);
      end
    end
  end

  // Output backpressure: random stall bursts, independent of out_valid.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
      stalled_cycles++;
    end else begin
      out_stall <= 1'b0;
      stall_left <= pick_gap();
    end
  end

  // Monitor: predict on every accepted pixel, shadow every accepted palette write, check every accepted result.
  always @(posedge clk) begin
    rgb_t want;
    in_fired <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      if (in_mode == MODE_WRITE) begin
        palette_shadow[in_entry_index] = in_entry_color;
        entries_written++;
      end else begin
        pending_colors.push_back(nearest_color(in_pix_red, in_pix_green, in_pix_blue,
                                               in_col_phase, in_row_phase));
      end
    end
    if (rst_n && out_valid && !out_stall) begin
      if (pending_colors.size() == 0) begin
        report_mismatch($sformatf("unexpected word %02h%02h%02h", out_red, out_green, out_blue));
      end else begin
        want = pending_colors.pop_front();
        pixels_mapped++;
        if (out_red !== want.red)
          report_mismatch($sformatf("out_red %02h, predicted %02h", out_red, want.red));
        if (out_green !== want.green)
          report_mismatch($sformatf("out_green %02h, predicted %02h", out_green, want.green));
        if (out_blue !== want.blue)
          report_mismatch($sformatf("out_blue %02h, predicted %02h", out_blue, want.blue));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d colors outstanding",
               cycle_count, pending_colors.size());
      $display("nearest_palette_color_mapper test failed");
      $finish;
    end
  end

  // Register write: setup cycle, then access cycle until pready; update the shadow.
  task automatic reg_write(reg_idx_t idx, int unsigned val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_DISTANCE_MODE: dist_mode = val[0];
      REG_DITHER_ENABLE: dither_on = val[0];
      REG_REDUCE_ENABLE: reduce_on = val[0];
      REG_GAIN_RED:      gain_r = val & 'h3ff;
      REG_GAIN_GREEN:    gain_g = val & 'h3ff;
      REG_GAIN_BLUE:     gain_b = val & 'h3ff;
      REG_PALETTE_COUNT: search_count = val & 'h1f;
      default: ;
    endcase
  endtask

  task automatic apply_config(logic manhattan, logic dither, logic reduce,
                              int gr, int gg, int gb, int count);
    reg_write(REG_DISTANCE_MODE, manhattan);
    reg_write(REG_DITHER_ENABLE, dither);
    reg_write(REG_REDUCE_ENABLE, reduce);
    reg_write(REG_GAIN_RED, gr);
    reg_write(REG_GAIN_GREEN, gg);
    reg_write(REG_GAIN_BLUE, gb);
    reg_write(REG_PALETTE_COUNT, count);
    settings_used++;
  endtask

  // Wait until every word was taken and every predicted color came out, then
  // give trailing palette writes time to leave the chain.
  task automatic wait_drained();
    while (word_queue.size() != 0 || in_valid || pending_colors.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_random(int n, bit flat_out);
    calm = flat_out;
    for (int i = 0; i < n; i++) word_queue.push_back(random_word());
    wait_drained();
    calm = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: fill every palette slot first, so no pixel ever reads an
    // unwritten entry, then map pixels at and near the corners and the center of the color cube.
    apply_config(DIST_SQUARED, 1'b0, 1'b0, 256, 256, 256, DEPTH);
    word_queue.push_back(entry_word(4'd0, 24'h000000));
    word_queue.push_back(entry_word(4'd1, 24'hffffff));
    word_queue.push_back(entry_word(4'd2, 24'hff0000));
    word_queue.push_back(entry_word(4'd3, 24'h00ff00));
    word_queue.push_back(entry_word(4'd4, 24'h0000ff));
    word_queue.push_back(entry_word(4'd5, 24'hffffff));  // duplicate of slot 1: tie
    for (int i = 6; i < DEPTH - 1; i++)
      word_queue.push_back(entry_word(4'(i), 24'($urandom_range(0, 24'hffffff))));
    word_queue.push_back(entry_word(4'd15, 24'h808080));
    word_queue.push_back(pixel_word(8'h00, 8'h00, 8'h00, 2'd0, 2'd0));
    word_queue.push_back(pixel_word(8'hff, 8'hff, 8'hff, 2'd3, 2'd3));
    word_queue.push_back(pixel_word(8'hff, 8'h00, 8'h00, 2'd0, 2'd3));
    word_queue.push_back(pixel_word(8'h00, 8'hff, 8'h00, 2'd3, 2'd0));
    word_queue.push_back(pixel_word(8'h00, 8'h00, 8'hff, 2'd1, 2'd2));
    word_queue.push_back(pixel_word(8'h80, 8'h80, 8'h80, 2'd2, 2'd1));
    word_queue.push_back(pixel_word(8'hfa, 8'h05, 8'h05, 2'd1, 2'd1));
    word_queue.push_back(pixel_word(8'h0a, 8'hfa, 8'h0a, 2'd2, 2'd2));
    word_queue.push_back(pixel_word(8'h80, 8'h80, 8'h81, 2'd0, 2'd1));
    wait_drained();

    // Fixed settings at the extremes: full search, count past the depth,
    // count zero, and zero gain.
    apply_config(DIST_SQUARED, 1'b0, 1'b0, 256, 256, 256, DEPTH);
    run_random(60, 1'b0);
    apply_config(DIST_MANHATTAN, 1'b1, 1'b0, 256, 256, 256, 31);
    run_random(60, 1'b0);
    apply_config(DIST_SQUARED, 1'b1, 1'b1, 1023, 1023, 1023, 0);
    run_random(20, 1'b0);
    apply_config(DIST_MANHATTAN, 1'b0, 1'b1, 0, 0, 0, 1);
    run_random(20, 1'b0);

    // Random settings; one phase runs with no idling on the input side.
    for (int p = 0; p < 4; p++) begin
      apply_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), rand_gain(), rand_gain(), rand_gain(),
                   ($urandom_range(0, 5) == 0) ? $urandom_range(0, 31)
                                                 : $urandom_range(1, DEPTH));
      run_random(55, p == 2);
    end

    if (pending_colors.size() != 0)
      report_mismatch($sformatf("%0d predicted colors never came out", pending_colors.size()));
    $display("mapped %0d pixels and stored %0d palette entries under %0d register settings",
             pixels_mapped, entries_written, settings_used);
    $display("%0d output stall cycles, %0d input pauses for a full drain, %0d mismatches",
             stalled_cycles, drain_pauses, mismatches);
    if (mismatches == 0) begin
      $display("nearest_palette_color_mapper test passed");
    end else begin
      $display("nearest_palette_color_mapper test failed");
    end
    $finish;
  end

endmodule
